// File: rtl/core/vtp_pkg.sv
// ---------------------------------------------------------------------------
// vtp_pkg
// Shared constants of the vertex transform / perspective unit.
// ---------------------------------------------------------------------------
package vtp_pkg;

  localparam int FIELD_W   = 32;  // width of a coordinate field on the channels
  localparam int CFG_W     = 64;  // width of one row register
  localparam int CFG_IDX_W = 3;   // register index width on the write port
  localparam int LANE_W    = 16;  // one coefficient lane inside a row register
  localparam int NUM_ROWS  = 4;
  localparam int NUM_COLS  = 4;
  localparam int NUM_LANES = 3;   // x, y and z

  localparam int DEF_COORD_WIDTH = 32;
  localparam int DEF_COEFF_WIDTH = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ROW0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3 = 3'd3;

  localparam logic [CFG_W-1:0] ROW0_RST = 64'd1;
  localparam logic [CFG_W-1:0] ROW1_RST = 64'd4096;
  localparam logic [CFG_W-1:0] ROW2_RST = 64'd0;
  localparam logic [CFG_W-1:0] ROW3_RST = 64'd0;

endpackage

// File: rtl/core/vtp_if.sv
// ---------------------------------------------------------------------------
// vtp_if
// Valid/ready channels carrying input points and transformed results.
// ---------------------------------------------------------------------------
interface vtp_in_if
  import vtp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] in_x;
  logic [FIELD_W-1:0] in_y;
  logic [FIELD_W-1:0] in_z;

  modport source (output valid, output in_x, output in_y, output in_z, input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

interface vtp_out_if
  import vtp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] out_x;
  logic [FIELD_W-1:0] out_y;
  logic [FIELD_W-1:0] out_z;
  logic               w_was_zero;
  logic               saturated;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output w_was_zero, output saturated, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input w_was_zero, input saturated, output ready);
endinterface

// File: rtl/core/vertex_transform_perspective_unit.sv
// ---------------------------------------------------------------------------
// vertex_transform_perspective_unit
// 4x4 homogeneous point transform with perspective divide and saturation.
// ---------------------------------------------------------------------------
// Usage:
//   in_i  carries one point (in_x, in_y, in_z, signed Q16.16) per transfer.
//   out_o carries one result per point: out_x/y/z, w_was_zero, saturated.
//   The matrix sits in four row registers written through cfg_we_i,
//   cfg_idx_i and cfg_data_i; write them only while no point is in flight.
//   Indexes above three are dropped.
// Throughput: one point per cycle, sustained while out_o is ready, with no dead cycles.
// Pipeline: COORD_WIDTH + 5 register stages (37 at the default width): one
//   stage of multipliers, one adder stage, one stage forming magnitudes and
//   the divisor, COORD_WIDTH + 1 divider stages that each settle one quotient
//   bit, and the saturating output register. The divider sets the depth.
// Stall: each stage holds its item while the stage after it is full and
//   not moving; bubbles collapse, so a stalled receiver still lets the
//   pipe fill before in_i.ready drops.
// Reset: all stage valid bits clear, the rows return to their reset
//   values; payload registers are not reset.
// A zero w divides by 2^(CF+PF) instead: the sums are scaled back to Q16.16
//   and w_was_zero is raised.
// ---------------------------------------------------------------------------
module vertex_transform_perspective_unit
  import vtp_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int COEFF_WIDTH = DEF_COEFF_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  vtp_in_if.sink               in_i,
  vtp_out_if.source            out_o
);

  localparam int CF = COEFF_WIDTH - 4;         // coefficient fraction bits
  localparam int PF = COORD_WIDTH / 2;         // coordinate fraction bits
  localparam int PW = COORD_WIDTH + COEFF_WIDTH;
  localparam int SW = PW + 2;                  // exact dot product width
  localparam int QB = COORD_WIDTH + 1;         // quotient bits kept
  localparam int NW = SW + PF;                 // dividend width
  localparam int L  = QB + 4;                  // pipeline depth
  localparam int S_PROD = 0;
  localparam int S_SUM  = 1;
  localparam int S_PREP = 2;
  localparam int S_DIV  = 3;

  localparam logic [SW-1:0] UNIT_DIV = SW'(1) << (CF + PF);
  localparam logic [QB-1:0] LIM      = QB'(1) << (COORD_WIDTH - 1);
  localparam logic [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // ---------------- configuration ----------------
  logic [NUM_ROWS-1:0][CFG_W-1:0] row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= ROW0_RST;
      row_q[1] <= ROW1_RST;
      row_q[2] <= ROW2_RST;
      row_q[3] <= ROW3_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROW0: row_q[0] <= cfg_data_i;
        REG_ROW1: row_q[1] <= cfg_data_i;
        REG_ROW2: row_q[2] <= cfg_data_i;
        REG_ROW3: row_q[3] <= cfg_data_i;
        default: ;  // drop writes beyond the row registers
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  // A stage takes a new item when it is empty or its item moves on.
  logic [L-1:0] vld_q, vld_d;
  logic [L:0]   rdy;
  logic [L-1:0] adv;

  assign rdy[L] = out_o.ready;
  for (genvar k = 0; k < L; k++) begin : g_rdy
    assign rdy[k] = !vld_q[k] || rdy[k+1];
  end
  assign adv = rdy[L-1:0];

  always_comb begin
    vld_d[0] = adv[0] ? in_i.valid : vld_q[0];
    for (int k = 1; k < L; k++) begin
      vld_d[k] = adv[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_i.ready = rdy[0];

  // ---------------- stage 0: products ----------------
  logic signed [NUM_LANES-1:0][COORD_WIDTH-1:0] crd;
  logic [FIELD_W-1:0] fld [NUM_LANES];

  assign fld[0] = in_i.in_x;
  assign fld[1] = in_i.in_y;
  assign fld[2] = in_i.in_z;

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_crd
    if (COORD_WIDTH <= FIELD_W) begin : g_cut
      assign crd[i] = fld[i][COORD_WIDTH-1:0];
    end else begin : g_ext
      assign crd[i] = {{(COORD_WIDTH-FIELD_W){1'b0}}, fld[i]};
    end
  end

  logic signed [PW-1:0]          prod_q [NUM_ROWS][NUM_LANES];
  logic signed [COEFF_WIDTH-1:0] k3_q   [NUM_ROWS];

  always_ff @(posedge clk_i) begin
    if (adv[S_PROD]) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int c = 0; c < NUM_LANES; c++) begin
          prod_q[r][c] <= PW'($signed(row_q[r][LANE_W*c +: COEFF_WIDTH]))
                        * PW'($signed(crd[c]));
        end
        k3_q[r] <= $signed(row_q[r][LANE_W*(NUM_COLS-1) +: COEFF_WIDTH]);
      end
    end
  end

  // ---------------- stage 1: dot products ----------------
  // The homogeneous one is 1 << PF, so column three is a plain shift.
  logic signed [SW-1:0] sum_q [NUM_ROWS];

  always_ff @(posedge clk_i) begin
    if (adv[S_SUM]) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        sum_q[r] <= SW'(prod_q[r][0]) + SW'(prod_q[r][1]) + SW'(prod_q[r][2])
                  + (SW'(k3_q[r]) <<< PF);
      end
    end
  end

  // ---------------- stage 2: magnitudes and divisor ----------------
  // With w zero, dividing by 2^(CF+PF) gives exactly the undivided scale-back.
  logic                          wneg, wzero;
  logic [SW-1:0]                 wmag, dsel;
  logic [NUM_LANES-1:0][SW-1:0]  rem_d;
  logic [NUM_LANES-1:0][QB-1:0]  nlo_d;
  logic [NUM_LANES-1:0]          ovf_d, neg_d;

  always_comb begin
    logic          xneg;
    logic [SW-1:0] xmag;
    logic [NW-1:0] num;
    wneg  = sum_q[3][SW-1];
    wmag  = wneg ? SW'(-sum_q[3]) : SW'(sum_q[3]);
    wzero = (sum_q[3] == '0);
    dsel  = wzero ? UNIT_DIV : wmag;
    for (int i = 0; i < NUM_LANES; i++) begin
      xneg     = sum_q[i][SW-1];
      xmag     = xneg ? SW'(-sum_q[i]) : SW'(sum_q[i]);
      num      = {xmag, {PF{1'b0}}};
      rem_d[i] = SW'(num[NW-1:QB]);
      nlo_d[i] = num[QB-1:0];
      ovf_d[i] = (SW'(num[NW-1:QB]) >= dsel);
      neg_d[i] = xneg ^ wneg;
    end
  end

  logic [SW-1:0]                 d_q;
  logic                          wz_q;
  logic [NUM_LANES-1:0][SW-1:0]  rem_q;
  logic [NUM_LANES-1:0][QB-1:0]  nlo_q;
  logic [NUM_LANES-1:0]          ovf_q, neg_q;

  always_ff @(posedge clk_i) begin
    if (adv[S_PREP]) begin
      d_q   <= dsel;
      wz_q  <= wzero;
      rem_q <= rem_d;
      nlo_q <= nlo_d;
      ovf_q <= ovf_d;
      neg_q <= neg_d;
    end
  end

  // ---------------- stages 3 .. QB+2: divider ----------------
  logic [NUM_LANES-1:0][QB-1:0] quo;
  logic [NUM_LANES-1:0]         dovf, dneg;
  logic                         dwz;

  vtp_div_pipe #(
    .SW (SW),
    .QB (QB)
  ) u_div (
    .clk_i (clk_i),
    .adv_i (adv[S_DIV +: QB]),
    .d_i   (d_q),
    .wz_i  (wz_q),
    .rem_i (rem_q),
    .nlo_i (nlo_q),
    .ovf_i (ovf_q),
    .neg_i (neg_q),
    .q_o   (quo),
    .ovf_o (dovf),
    .neg_o (dneg),
    .wz_o  (dwz)
  );

  // ---------------- last stage: saturate and hold for the receiver ----------
  logic [NUM_LANES-1:0][COORD_WIDTH-1:0] res_d, res_q;
  logic [NUM_LANES-1:0]                  clip;
  logic                                  wz_out_q, sat_q;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      if (dneg[i]) begin
        clip[i]  = dovf[i] || (quo[i] > LIM);
        res_d[i] = clip[i] ? CMIN : COORD_WIDTH'(-quo[i]);
      end else begin
        clip[i]  = dovf[i] || (quo[i] > (LIM - QB'(1)));
        res_d[i] = clip[i] ? CMAX : quo[i][COORD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[L-1]) begin
      res_q    <= res_d;
      wz_out_q <= dwz;
      sat_q    <= |clip;
    end
  end

  logic [NUM_LANES-1:0][FIELD_W-1:0] res_fld;
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_out
    if (COORD_WIDTH <= FIELD_W) begin : g_ext
      assign res_fld[i] = FIELD_W'(res_q[i]);
    end else begin : g_cut
      assign res_fld[i] = res_q[i][FIELD_W-1:0];
    end
  end

  assign out_o.valid      = vld_q[L-1];
  assign out_o.out_x      = res_fld[0];
  assign out_o.out_y      = res_fld[1];
  assign out_o.out_z      = res_fld[2];
  assign out_o.w_was_zero = wz_out_q;
  assign out_o.saturated  = sat_q;

  // ---------------- assertions ----------------
  // Input back-pressure only when every stage is full down to a stalled output.
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rdy[0] |-> (&vld_q) && !out_o.ready)
    else $error("input stalled while the pipeline has room");

  // A stalled result stays in the output register.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[L-1] && !out_o.ready) |=> vld_q[L-1] && $stable(res_q))
    else $error("stalled result lost or changed");

  // A saturated result carries at least one clamped coordinate.
  a_sat_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[L-1] && sat_q) |->
      (res_q[0] == CMAX || res_q[0] == CMIN || res_q[1] == CMAX ||
       res_q[1] == CMIN || res_q[2] == CMAX || res_q[2] == CMIN))
    else $error("saturated flag without a clamped coordinate");

endmodule

// File: rtl/core/vtp_div_pipe.sv
// ---------------------------------------------------------------------------
// vtp_div_pipe
// Pipelined restoring divider, one quotient bit per stage, three lanes
// sharing one divisor.
// ---------------------------------------------------------------------------
module vtp_div_pipe
  import vtp_pkg::*;
#(
  parameter int SW = 50,  // divisor / remainder width
  parameter int QB = 33   // quotient bits, one stage each
) (
  input  logic                             clk_i,
  input  logic [QB-1:0]                    adv_i,
  input  logic [SW-1:0]                    d_i,
  input  logic                             wz_i,
  input  logic [NUM_LANES-1:0][SW-1:0]     rem_i,
  input  logic [NUM_LANES-1:0][QB-1:0]     nlo_i,
  input  logic [NUM_LANES-1:0]             ovf_i,
  input  logic [NUM_LANES-1:0]             neg_i,
  output logic [NUM_LANES-1:0][QB-1:0]     q_o,
  output logic [NUM_LANES-1:0]             ovf_o,
  output logic [NUM_LANES-1:0]             neg_o,
  output logic                             wz_o
);

  logic [QB-1:0][SW-1:0]                 d_q;
  logic [QB-1:0]                         wz_q;
  logic [QB-1:0][NUM_LANES-1:0][SW-1:0]  rem_q;
  logic [QB-1:0][NUM_LANES-1:0][QB-1:0]  nlo_q;
  logic [QB-1:0][NUM_LANES-1:0][QB-1:0]  quo_q;
  logic [QB-1:0][NUM_LANES-1:0]          ovf_q;
  logic [QB-1:0][NUM_LANES-1:0]          neg_q;

  for (genvar j = 0; j < QB; j++) begin : g_stage
    logic [SW-1:0]                    src_d;
    logic                             src_wz;
    logic [NUM_LANES-1:0][SW-1:0]     src_rem;
    logic [NUM_LANES-1:0][QB-1:0]     src_nlo;
    logic [NUM_LANES-1:0][QB-1:0]     src_quo;
    logic [NUM_LANES-1:0]             src_ovf;
    logic [NUM_LANES-1:0]             src_neg;
    logic [NUM_LANES-1:0][SW-1:0]     rem_d;
    logic [NUM_LANES-1:0][QB-1:0]     quo_d;

    if (j == 0) begin : g_first
      assign src_d   = d_i;
      assign src_wz  = wz_i;
      assign src_rem = rem_i;
      assign src_nlo = nlo_i;
      assign src_quo = '0;
      assign src_ovf = ovf_i;
      assign src_neg = neg_i;
    end else begin : g_next
      assign src_d   = d_q[j-1];
      assign src_wz  = wz_q[j-1];
      assign src_rem = rem_q[j-1];
      assign src_nlo = nlo_q[j-1];
      assign src_quo = quo_q[j-1];
      assign src_ovf = ovf_q[j-1];
      assign src_neg = neg_q[j-1];
    end

    // Shift in the next dividend bit, subtract when the divisor fits.
    always_comb begin
      logic [SW:0] trial;
      logic        fits;
      for (int i = 0; i < NUM_LANES; i++) begin
        trial    = {src_rem[i], src_nlo[i][QB-1]};
        fits     = (trial >= {1'b0, src_d});
        rem_d[i] = fits ? SW'(trial - {1'b0, src_d}) : trial[SW-1:0];
        quo_d[i] = {src_quo[i][QB-2:0], fits};
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i[j]) begin
        d_q[j]   <= src_d;
        wz_q[j]  <= src_wz;
        rem_q[j] <= rem_d;
        quo_q[j] <= quo_d;
        ovf_q[j] <= src_ovf;
        neg_q[j] <= src_neg;
        for (int i = 0; i < NUM_LANES; i++) begin
          nlo_q[j][i] <= {src_nlo[i][QB-2:0], 1'b0};
        end
      end
    end
  end

  assign q_o   = quo_q[QB-1];
  assign ovf_o = ovf_q[QB-1];
  assign neg_o = neg_q[QB-1];
  assign wz_o  = wz_q[QB-1];

endmodule
